// ===== rtl/dvrl_pkg.sv =====
// Package for the dual velocity ramp limiter.
// Holds the shared widths, types, command codes and register indexes.
// Has no dependencies of its own.
package dvrl_pkg;

	localparam int unsigned VelW  = 16;
	localparam int unsigned StepW = 15;
	localparam int unsigned AgeW  = 16;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;

	typedef logic signed [VelW-1:0] vel_t;
	typedef logic [StepW-1:0]       step_t;
	typedef logic [AgeW-1:0]        age_t;
	typedef logic [CfgIdxW-1:0]     cfg_idx_t;
	typedef logic [CfgDataW-1:0]    cfg_data_t;

	localparam logic CMD_SETPOINT = 1'b0;
	localparam logic CMD_TICK     = 1'b1;

	localparam cfg_idx_t REG_ACCEL_STEP    = 2'd0;
	localparam cfg_idx_t REG_DECEL_STEP    = 2'd1;
	localparam cfg_idx_t REG_TIMEOUT_TICKS = 2'd2;

	localparam step_t ACCEL_RESET   = 15'd256;
	localparam step_t DECEL_RESET   = 15'd512;
	localparam age_t  TIMEOUT_RESET = 16'd50;
	localparam age_t  AGE_MAX       = 16'hFFFF;

	typedef struct packed {
		step_t accel;
		step_t decel;
	} ramp_cfg_t;

endpackage

// ===== rtl/dvrl_item_if.sv =====
// Request channel of the dual velocity ramp limiter: setpoints and ticks.
// Depends on dvrl_pkg for the velocity type.
interface dvrl_item_if import dvrl_pkg::*; ();
	logic valid;
	logic ready;
	logic command;
	vel_t left_target;
	vel_t right_target;
	logic period_overrun;

	modport source (output valid, command, left_target, right_target, period_overrun,
		input ready);
	modport sink (input valid, command, left_target, right_target, period_overrun,
		output ready);
endinterface

// ===== rtl/dvrl_result_if.sv =====
// Result channel of the dual velocity ramp limiter: ramped velocities.
// Depends on dvrl_pkg for the velocity type.
interface dvrl_result_if import dvrl_pkg::*; ();
	logic valid;
	logic ready;
	vel_t left_velocity;
	vel_t right_velocity;
	logic command_expired;

	modport source (output valid, left_velocity, right_velocity, command_expired,
		input ready);
	modport sink (input valid, left_velocity, right_velocity, command_expired,
		output ready);
endinterface

// ===== rtl/dual_velocity_ramp_limiter.sv =====
// Dual velocity ramp limiter, top level.
// A request is registered in the input stage on acceptance; a non-overrun tick's result is
// held and offered in the result register; a waiting result can stall it in the input stage.
// Throughput: one request per cycle; the result register lets a new request
// in while an earlier result waits, but a non-overrun tick held behind that result holds the input.
// Reset clears velocities and targets, saturates the command age and loads
// the default step and timeout registers. Depends on dvrl_pkg, the interfaces and dvrl_ramp.
module dual_velocity_ramp_limiter import dvrl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  cfg_idx_t             cfg_index,
	input  cfg_data_t            cfg_wdata,
	dvrl_item_if.sink            item,
	dvrl_result_if.source        result
);

	ramp_cfg_t cfg_q;
	age_t      timeout_q;

	logic valid_s1;
	logic command_s1;
	vel_t left_target_s1;
	vel_t right_target_s1;
	logic overrun_s1;

	vel_t left_now_q;
	vel_t right_now_q;
	vel_t left_request_q;
	vel_t right_request_q;
	age_t age_q;

	logic out_valid_q;
	vel_t out_left_q;
	vel_t out_right_q;
	logic out_expired_q;

	age_t age_next;
	logic expired;
	logic emits;
	logic s1_go;
	vel_t left_goal;
	vel_t right_goal;
	vel_t left_next;
	vel_t right_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel <= ACCEL_RESET;
			cfg_q.decel <= DECEL_RESET;
			timeout_q   <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACCEL_STEP:    cfg_q.accel <= cfg_wdata[StepW-1:0];
				REG_DECEL_STEP:    cfg_q.decel <= cfg_wdata[StepW-1:0];
				REG_TIMEOUT_TICKS: timeout_q   <= cfg_wdata[AgeW-1:0];
				default: ;
			endcase
		end
	end

	assign age_next   = (age_q == AGE_MAX) ? age_q : age_q + age_t'(1);
	assign expired    = age_next > timeout_q;
	assign emits      = (command_s1 == CMD_TICK) && !overrun_s1;
	assign s1_go      = valid_s1 && (!emits || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || s1_go;
	assign left_goal  = expired ? '0 : left_request_q;
	assign right_goal = expired ? '0 : right_request_q;

	dvrl_ramp u_ramp_left (
		.now    (left_now_q),
		.target (left_goal),
		.cfg    (cfg_q),
		.next   (left_next)
	);

	dvrl_ramp u_ramp_right (
		.now    (right_now_q),
		.target (right_goal),
		.cfg    (cfg_q),
		.next   (right_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			command_s1      <= item.command;
			left_target_s1  <= item.left_target;
			right_target_s1 <= item.right_target;
			overrun_s1      <= item.period_overrun;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_now_q      <= '0;
			right_now_q     <= '0;
			left_request_q  <= '0;
			right_request_q <= '0;
			age_q           <= AGE_MAX;
		end else if (s1_go) begin
			if (command_s1 == CMD_SETPOINT) begin
				left_request_q  <= left_target_s1;
				right_request_q <= right_target_s1;
				age_q           <= '0;
			end else begin
				age_q <= age_next;
				if (!overrun_s1) begin
					left_now_q  <= left_next;
					right_now_q <= right_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && emits) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emits) begin
			out_left_q    <= left_next;
			out_right_q   <= right_next;
			out_expired_q <= expired;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.left_velocity   = out_left_q;
	assign result.right_velocity  = out_right_q;
	assign result.command_expired = out_expired_q;

	a_setpoint_clears_age: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && command_s1 == CMD_SETPOINT) |=> (age_q == '0))
		else $error("command age not cleared by a setpoint");

	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_go && emits))
		else $error("result raised without a tick to cause it");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (valid_s1 && out_valid_q && !result.ready))
		else $error("request refused without a pending stalled result");

	a_overrun_keeps_velocity: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && command_s1 == CMD_TICK && overrun_s1) |=> $stable(left_now_q)
		&& $stable(right_now_q))
		else $error("velocity moved on an overrun tick");

endmodule

// ===== rtl/dvrl_ramp.sv =====
// One channel of the ramp: steps the velocity toward its target.
// Accel step moves away from zero, decel step toward it,
// with zero counted as negative. Depends on dvrl_pkg.
module dvrl_ramp import dvrl_pkg::*; (
	input  vel_t      now,
	input  vel_t      target,
	input  ramp_cfg_t cfg,
	output vel_t      next
);

	logic signed [VelW:0] d_up;
	logic signed [VelW:0] d_dn;
	logic signed [VelW:0] up;
	logic signed [VelW:0] dn;
	logic signed [VelW:0] v_ext;

	assign v_ext = {now[VelW-1], now};
	assign d_up  = {target[VelW-1], target} - v_ext;
	assign d_dn  = v_ext - {target[VelW-1], target};
	assign up    = signed'({2'b00, cfg.accel});
	assign dn    = signed'({2'b00, cfg.decel});

	always_comb begin
		next = target;
		if (now > 0) begin
			if (d_up > up) begin
				next = vel_t'(v_ext + up);
			end else if (d_dn > dn) begin
				next = vel_t'(v_ext - dn);
			end
		end else begin
			if (d_dn > up) begin
				next = vel_t'(v_ext - up);
			end else if (d_up > dn) begin
				next = vel_t'(v_ext + dn);
			end
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for dual_velocity_ramp_limiter: directed and random setpoint and tick requests.
// A scoreboard class predicts each ramp step and checks the results in order.
// Depends on dvrl_pkg, dvrl_item_if, dvrl_result_if and the block itself.
module testbench;
	import dvrl_pkg::*;

	localparam cfg_idx_t REG_UNUSED = 2'd3;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 220;
	localparam int unsigned SETTLE_CYCLES = 6;

	typedef struct packed {
		vel_t left;
		vel_t right;
		logic expired;
	} ramp_sample_t;

	class velocity_ramp_board;
		step_t accel_step;
		step_t decel_step;
		age_t timeout_ticks;
		vel_t left_now;
		vel_t right_now;
		vel_t left_request;
		vel_t right_request;
		age_t command_age;
		ramp_sample_t expected_velocities[$];
		int unsigned failures;
		int unsigned setpoints;
		int unsigned ticks;
		int unsigned overruns;
		int unsigned results_seen;
		int unsigned expiries;
		int unsigned settings;

		function new();
			accel_step = ACCEL_RESET;
			decel_step = DECEL_RESET;
			timeout_ticks = TIMEOUT_RESET;
			left_now = '0;
			right_now = '0;
			left_request = '0;
			right_request = '0;
			command_age = AGE_MAX;
			failures = 0;
			setpoints = 0;
			ticks = 0;
			overruns = 0;
			results_seen = 0;
			expiries = 0;
			settings = 1;
		endfunction

		function void write_register(cfg_idx_t idx, cfg_data_t data);
			case (idx)
				REG_ACCEL_STEP: accel_step = data[StepW-1:0];
				REG_DECEL_STEP: decel_step = data[StepW-1:0];
				REG_TIMEOUT_TICKS: timeout_ticks = data[AgeW-1:0];
				default: ;
			endcase
		endfunction

		function vel_t step_toward(vel_t v, vel_t t);
			int up;
			int dn;
			int vi;
			int ti;
			int r;
			up = int'(accel_step);
			dn = int'(decel_step);
			vi = int'(v);
			ti = int'(t);
			if (vi > 0) begin
				if (ti - vi > up) r = vi + up;
				else if (vi - ti > dn) r = vi - dn;
				else r = ti;
			end else begin
				if (vi - ti > up) r = vi - up;
				else if (ti - vi > dn) r = vi + dn;
				else r = ti;
			end
			return r[VelW-1:0];
		endfunction

		function void note_request(logic cmd, vel_t lt, vel_t rt, logic overrun);
			ramp_sample_t s;
			logic expired;
			if (cmd == CMD_SETPOINT) begin
				left_request = lt;
				right_request = rt;
				command_age = '0;
				setpoints++;
				return;
			end
			ticks++;
			if (command_age != AGE_MAX) command_age++;
			expired = command_age > timeout_ticks;
			if (overrun) begin
				overruns++;
				return;
			end
			left_now = step_toward(left_now, expired ? vel_t'(0) : left_request);
			right_now = step_toward(right_now, expired ? vel_t'(0) : right_request);
			s.left = left_now;
			s.right = right_now;
			s.expired = expired;
			expected_velocities.push_back(s);
		endfunction

		function void check_result(vel_t lv, vel_t rv, logic exp_flag);
			ramp_sample_t s;
			results_seen++;
			if (expected_velocities.size() == 0) begin
				$error("Result with no request pending: left %0d, right %0d, expired %0b",
					lv, rv, exp_flag);
				failures++;
				return;
			end
			s = expected_velocities.pop_front();
			if (s.expired) expiries++;
			if (lv !== s.left) begin
				$error("left_velocity mismatch: expected %0d, actual %0d", s.left, lv);
				failures++;
			end
			if (rv !== s.right) begin
				$error("right_velocity mismatch: expected %0d, actual %0d", s.right, rv);
				failures++;
			end
			if (exp_flag !== s.expired) begin
				$error("command_expired mismatch: expected %0b, actual %0b",
					s.expired, exp_flag);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return expected_velocities.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	cfg_data_t cfg_wdata;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	velocity_ramp_board board = new();

	dvrl_item_if item_ch ();
	dvrl_result_if result_ch ();

	dual_velocity_ramp_limiter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item(item_ch),
		.result(result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3_200_000;
		$display("Run stopped by the time limit with %0d results outstanding.", board.pending());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				board.check_result(result_ch.left_velocity, result_ch.right_velocity,
					result_ch.command_expired);
			end
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_request(input logic cmd, input vel_t lt, input vel_t rt,
			input logic overrun);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.command <= cmd;
		item_ch.left_target <= lt;
		item_ch.right_target <= rt;
		item_ch.period_overrun <= overrun;
		do @(posedge clk); while (!item_ch.ready);
		board.note_request(cmd, lt, rt, overrun);
	endtask

	task automatic settle(input int unsigned extra);
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_settings(input cfg_data_t accel, input cfg_data_t decel,
			input cfg_data_t timeout, input bit poke_unused);
		cfg_we <= 1'b1;
		cfg_index <= REG_ACCEL_STEP;
		cfg_wdata <= accel;
		@(posedge clk);
		board.write_register(REG_ACCEL_STEP, accel);
		cfg_index <= REG_DECEL_STEP;
		cfg_wdata <= decel;
		@(posedge clk);
		board.write_register(REG_DECEL_STEP, decel);
		cfg_index <= REG_TIMEOUT_TICKS;
		cfg_wdata <= timeout;
		@(posedge clk);
		board.write_register(REG_TIMEOUT_TICKS, timeout);
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_wdata <= cfg_data_t'($urandom());
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		board.settings++;
	endtask

	function automatic vel_t pick_target();
		int r;
		case ($urandom_range(5))
			0: r = 32767;
			1: r = -32768;
			2: r = 0;
			3: r = int'($urandom_range(2047)) - 1024;
			default: r = int'($urandom());
		endcase
		return r[VelW-1:0];
	endfunction

	initial begin
		int unsigned setpoint_pct;
		cfg_data_t accel;
		cfg_data_t decel;
		cfg_data_t timeout;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ACCEL_STEP;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		item_ch.valid = 1'b0;
		item_ch.command = CMD_TICK;
		item_ch.left_target = '0;
		item_ch.right_target = '0;
		item_ch.period_overrun = 1'b0;
		result_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the saturated age makes the first tick expire.
		send_request(CMD_TICK, 16'sd100, -16'sd100, 1'b0);
		send_request(CMD_TICK, '0, '0, 1'b1);
		send_request(CMD_SETPOINT, 16'sh7FFF, 16'sh8000, 1'b1);
		repeat (4) send_request(CMD_TICK, '0, '0, 1'b0);
		send_request(CMD_TICK, 16'sh7FFF, 16'sh7FFF, 1'b1);
		send_request(CMD_TICK, '0, '0, 1'b0);
		// Reverse direction so that both channels decelerate through zero.
		send_request(CMD_SETPOINT, 16'sh8000, 16'sh7FFF, 1'b0);
		repeat (6) send_request(CMD_TICK, '0, '0, 1'b0);
		send_request(CMD_SETPOINT, 16'sd5, -16'sd5, 1'b0);
		repeat (4) send_request(CMD_TICK, '0, '0, 1'b0);
		send_request(CMD_SETPOINT, 16'sh7FFF, 16'sh8000, 1'b0);
		send_request(CMD_TICK, '0, '0, 1'b0);
		settle(SETTLE_CYCLES);

		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin accel = 16'd32767; decel = 16'd32767; timeout = 16'hFFFF;
					setpoint_pct = 25; end
				1: begin accel = 16'h8000; decel = 16'd0; timeout = 16'd3;
					setpoint_pct = 20; end
				2: begin accel = 16'd200; decel = 16'd700; timeout = 16'd8;
					setpoint_pct = 15; end
				3: begin accel = 16'hFFFF; decel = 16'd0; timeout = 16'd20;
					setpoint_pct = 10; end
				4: begin accel = 16'd1; decel = 16'hFFFF; timeout = 16'd0;
					setpoint_pct = 30; end
				5: begin accel = cfg_data_t'($urandom_range(1, 2000));
					decel = cfg_data_t'($urandom_range(1, 2000));
					timeout = cfg_data_t'($urandom_range(2, 30)); setpoint_pct = 15; end
				6: begin accel = cfg_data_t'($urandom()); decel = cfg_data_t'($urandom());
					timeout = cfg_data_t'($urandom()); setpoint_pct = 20; end
				default: begin accel = 16'd300; decel = 16'd300; timeout = 16'd12;
					setpoint_pct = 8; end
			endcase
			write_settings(accel, decel, timeout, phase == 3);
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 74; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 74; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2) settle(0);
				if ($urandom_range(99) < setpoint_pct)
					send_request(CMD_SETPOINT, pick_target(), pick_target(),
						1'($urandom_range(1)));
				else
					send_request(CMD_TICK, pick_target(), pick_target(),
						$urandom_range(9) == 0);
			end
			settle(SETTLE_CYCLES);
		end

		$display("Sent %0d setpoints and %0d ticks (%0d with overrun) over %0d register settings.",
			board.setpoints, board.ticks, board.overruns, board.settings);
		$display("Checked %0d ramp results, %0d of them after command expiry.",
			board.results_seen, board.expiries);
		if (board.failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
